FILE: rtl/lgs_pkg.sv
// Shared types, constants and the cell rule for the life grid block.
`timescale 1ns / 1ps

package lgs_pkg;

  // Largest grid the row store and its request word are sized for.
  localparam int MAX_GRID = 64;
  localparam int IDX_W    = 6;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_STEP  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_STEP,
    ST_RESP
  } state_e;

  // Request from the controller to the row store.
  typedef struct packed {
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [MAX_GRID-1:0] wr_data;
  } mem_req_t;

  // Conway's rule for one cell from its eight neighbours.
  function automatic logic next_cell(logic [7:0] nb, logic alive);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'd0, nb[i]};
    end
    return (cnt == 4'd3) || (alive && (cnt == 4'd2));
  endfunction

endpackage

FILE: rtl/lgs_if.sv
// Valid/ready channel interfaces for the operation words and result words.
`timescale 1ns / 1ps

interface lgs_in_if import lgs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;

  modport source (output valid, output op, output col, output row, input ready);
  modport sink (input valid, input op, input col, input row, output ready);
endinterface

interface lgs_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic done_res;

  modport source (output valid, output cell_alive, output done_res, input ready);
  modport sink (input valid, input cell_alive, input done_res, output ready);
endinterface

FILE: rtl/life_grid_generation_step.sv
// Top level of the life grid: controller, window registers and the row store.
// A set, clear or read word reads the row of its cell from the store and passes through
// ST_CELL and ST_RESP to the output register; a cell off the grid skips ST_CELL and the store.
// An advance word sweeps the rows one per cycle through the store's read and write
// ports and then passes to ST_RESP; no further word is taken until the controller is
// back in ST_IDLE, after its result has gone to the output register.
// Reset clears the per-row valid flags at once, so the grid reads dead straight away.
`timescale 1ns / 1ps

module life_grid_generation_step import lgs_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lgs_in_if.sink    in_i,
  lgs_out_if.source out_o
);

  localparam int              AW       = $clog2(GRID_SIZE);
  localparam int              CW       = $clog2(GRID_SIZE + 2);
  localparam logic [IDX_W:0]  GRID_LIM = (IDX_W + 1)'(GRID_SIZE);
  localparam logic [CW-1:0]   NROWS    = CW'(GRID_SIZE);
  localparam logic [CW-1:0]   LAST     = CW'(GRID_SIZE + 1);

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [IDX_W-1:0]     col_q, col_d;
  logic [IDX_W-1:0]     row_q, row_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [GRID_SIZE-1:0] win_up_q, win_up_d;
  logic [GRID_SIZE-1:0] win_mid_q, win_mid_d;
  logic                 res_alive_q, res_alive_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_alive_q, out_alive_d;

  mem_req_t             mem_req;
  logic [GRID_SIZE-1:0] rd_data;
  logic [GRID_SIZE-1:0] row_in;
  logic [GRID_SIZE-1:0] row_nxt;
  logic [GRID_SIZE-1:0] cell_mask;
  logic                 in_on_grid;

  // Row store.
  lgs_row_mem #(
    .GRID_SIZE(GRID_SIZE)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  // Rule over the three-row window; the row below is the word now leaving the store.
  lgs_row_rule #(
    .GRID_SIZE(GRID_SIZE)
  ) u_rule (
    .up_i (win_up_q),
    .mid_i(win_mid_q),
    .dn_i (row_in),
    .nxt_o(row_nxt)
  );

  // Read data holds a real row only in the cycles after a row read; past the
  // bottom edge the window is fed a dead row.
  assign row_in = ((cnt_q != '0) && (cnt_q <= NROWS)) ? rd_data : '0;

  assign in_on_grid = ({1'b0, in_i.col} < GRID_LIM) && ({1'b0, in_i.row} < GRID_LIM);
  assign cell_mask  = GRID_SIZE'(1) << col_q[AW-1:0];

  // Next state, store requests and result capture.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    win_up_d    = win_up_q;
    win_mid_d   = win_mid_q;
    res_alive_d = res_alive_q;
    out_vld_d   = out_vld_q;
    out_alive_d = out_alive_q;
    mem_req     = '0;
    in_i.ready  = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d        = op_e'(in_i.op);
          col_d       = in_i.col;
          row_d       = in_i.row;
          res_alive_d = 1'b0;
          if (op_e'(in_i.op) == OP_STEP) begin
            cnt_d     = '0;
            win_up_d  = '0;
            win_mid_d = '0;
            state_d   = ST_STEP;
          end else if (in_on_grid) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = in_i.row;
            state_d         = ST_CELL;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      // Row of the addressed cell has arrived: update or sample it.
      ST_CELL: begin
        case (op_q)
          OP_SET: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = row_q;
            mem_req.wr_data = MAX_GRID'(rd_data | cell_mask);
          end
          OP_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = row_q;
            mem_req.wr_data = MAX_GRID'(rd_data & ~cell_mask);
          end
          OP_READ: begin
            res_alive_d = rd_data[col_q[AW-1:0]];
          end
          default: begin
            res_alive_d = 1'b0;
          end
        endcase
        state_d = ST_RESP;
      end

      // Sweep: read row k, and write back row k - 2 as row k - 1 arrives.
      ST_STEP: begin
        if (cnt_q < NROWS) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = IDX_W'(cnt_q);
        end
        if (cnt_q >= CW'(2)) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(cnt_q - CW'(2));
          mem_req.wr_data = MAX_GRID'(row_nxt);
        end
        if (cnt_q != '0) begin
          win_up_d  = win_mid_q;
          win_mid_d = row_in;
        end
        if (cnt_q == LAST) begin
          state_d = ST_RESP;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d   = 1'b1;
          out_alive_d = res_alive_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    col_q       <= col_d;
    row_q       <= row_d;
    win_up_q    <= win_up_d;
    win_mid_q   <= win_mid_d;
    res_alive_q <= res_alive_d;
    out_alive_q <= out_alive_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.cell_alive = out_alive_q;
  assign out_o.done_res   = 1'b1;

endmodule

FILE: rtl/lgs_row_mem.sv
// Row store of the grid: one write and one registered read a cycle.
`timescale 1ns / 1ps

module lgs_row_mem import lgs_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             req_i,
  output logic [GRID_SIZE-1:0] rd_data_o
);

  localparam int AW = $clog2(GRID_SIZE);

  logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_q;
  logic [GRID_SIZE-1:0] rd_data_q;
  logic                 rd_vld_q;

  // Storage array and its read register.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data[GRID_SIZE-1:0];
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr[AW-1:0]];
    end
  end

  // A row never written since reset reads as all dead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/lgs_row_rule.sv
// Next generation of one row from the old rows above, at and below it.
`timescale 1ns / 1ps

module lgs_row_rule import lgs_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic [GRID_SIZE-1:0] up_i,
  input  logic [GRID_SIZE-1:0] mid_i,
  input  logic [GRID_SIZE-1:0] dn_i,
  output logic [GRID_SIZE-1:0] nxt_o
);

  logic [GRID_SIZE+1:0] up_x;
  logic [GRID_SIZE+1:0] mid_x;
  logic [GRID_SIZE+1:0] dn_x;

  // Pad with a dead column on either side for the left and right edges.
  assign up_x  = {1'b0, up_i, 1'b0};
  assign mid_x = {1'b0, mid_i, 1'b0};
  assign dn_x  = {1'b0, dn_i, 1'b0};

  // Each cell looks at its own three by three window.
  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
    assign nxt_o[c] = next_cell({up_x[c+2:c], mid_x[c+2], mid_x[c], dn_x[c+2:c]},
                                mid_i[c]);
  end

endmodule

FILE: rtl/lgs_checker.sv
// Port-level checks on the life grid top level, and the bind that attaches them.
`timescale 1ns / 1ps

module lgs_checker import lgs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_cell_alive_i,
  input logic       out_done_res_i
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_cell_alive_i))
    else $error("result word changed while stalled");

  // Every result word reports completion.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_done_res_i)
    else $error("result word without completion flag");

  // Once a word is taken the block is busy with it in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again straight after an accepted word");

  // A new result appears only after a busy cycle.
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without the block being busy");

  // An advance word keeps the input closed at a single sample point within the sweep.
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_STEP) |=> ##2 !in_ready_i)
    else $error("input reopened during a generation sweep");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_op_i         (in_i.op),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_cell_alive_i(out_o.cell_alive),
  .out_done_res_i  (out_o.done_res)
);

FILE: tb/testbench.sv
// Self-checking testbench for the life grid: scoreboard, word drivers and run control.
`timescale 1ns / 1ps

module testbench;
  import lgs_pkg::*;

  localparam int GRID           = 64;
  localparam int WORD_TARGET    = 950;
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected result word.
  typedef struct packed {
    logic cell_alive;
    logic done_res;
  } cell_result_t;

  // Keeps its own copy of the grid and the queue of result words still owed.
  class life_board;
    bit [MAX_GRID-1:0] cells [MAX_GRID];
    cell_result_t      pending_results [$];
    int unsigned       mismatch_count;
    int unsigned       op_count [4];
    int unsigned       alive_reads;

    function new();
      foreach (cells[r]) cells[r] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      mismatch_count = 0;
      alive_reads    = 0;
    endfunction

    // Conway's rule over the whole grid from a snapshot; cells off the grid are dead.
    function void next_generation();
      bit [MAX_GRID-1:0] prev [MAX_GRID];
      int n;
      int rr;
      int cc;
      prev = cells;
      for (int r = 0; r < GRID; r++) begin
        for (int c = 0; c < GRID; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID && cc >= 0 && cc < GRID &&
                  prev[rr][cc]) begin
                n++;
              end
            end
          end
          cells[r][c] = (n == 3) || (prev[r][c] && n == 2);
        end
      end
    endfunction

    // Applies an accepted operation word and queues the result word it owes.
    function void apply_word(op_e op, logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
      cell_result_t res;
      bit           on_grid;
      res.cell_alive = 1'b0;
      res.done_res   = 1'b1;
      on_grid = (int'(col) < GRID) && (int'(row) < GRID);
      case (op)
        OP_SET: begin
          if (on_grid) cells[row][col] = 1'b1;
        end
        OP_CLEAR: begin
          if (on_grid) cells[row][col] = 1'b0;
        end
        OP_READ: begin
          if (on_grid) res.cell_alive = cells[row][col];
          if (res.cell_alive) alive_reads++;
        end
        default: begin
          next_generation();
        end
      endcase
      op_count[int'(op)]++;
      pending_results.push_back(res);
    endfunction

    // Compares a result word with the oldest one owed.
    function void check_result(logic cell_alive, logic done_res);
      cell_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: cell_alive=%0b done_res=%0b", cell_alive, done_res);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (cell_alive !== want.cell_alive) begin
        $error("cell_alive: expected %0b, got %0b", want.cell_alive, cell_alive);
        mismatch_count++;
      end
      if (done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, done_res);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm_phase;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  life_board   board = new();

  lgs_in_if  in_if ();
  lgs_out_if out_if ();

  life_grid_generation_step #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    if (calm_phase) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 31);
    end
  end

  // Watch both channels, feed the scoreboard and catch a hung block.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      board.check_result(out_if.cell_alive, out_if.done_res);
    end
    if (in_if.valid && in_if.ready) begin
      board.apply_word(op_e'(in_if.op), in_if.col, in_if.row);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one operation word, possibly after a random idle stretch, and waits for it to go.
  task automatic send_word(op_e op, int col, int row);
    if (!calm_phase && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 31);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.col   <= col[IDX_W-1:0];
    in_if.row   <= row[IDX_W-1:0];
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // Holds the sender back until every owed result word has arrived.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_results.size() != 0);
  endtask

  // Focus points favour the corners and edges so the border rule is exercised often.
  function automatic int pick_focus();
    case ($urandom_range(3))
      0:       return $urandom_range(2);
      1:       return GRID - 1 - $urandom_range(2);
      default: return $urandom_range(GRID - 1);
    endcase
  endfunction

  function automatic int near(int centre);
    int v;
    v = centre + $urandom_range(4) - 2;
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return v;
  endfunction

  // Seed a small pattern, let it evolve, then probe around it.
  task automatic pattern_scene();
    int fc;
    int fr;
    fc = pick_focus();
    fr = pick_focus();
    repeat ($urandom_range(3, 9)) begin
      send_word(($urandom_range(9) == 0) ? OP_CLEAR : OP_SET, near(fc), near(fr));
    end
    repeat ($urandom_range(1, 3)) begin
      send_word(OP_STEP, $urandom_range(63), $urandom_range(63));
    end
    repeat ($urandom_range(3, 8)) begin
      send_word(OP_READ, near(fc), near(fr));
    end
  endtask

  // Words with fully random content.
  task automatic noise_scene();
    repeat ($urandom_range(1, 4)) begin
      send_word(op_e'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    bit drained_mid;
    in_if.valid  = 1'b0;
    in_if.op     = OP_SET;
    in_if.col    = '0;
    in_if.row    = '0;
    out_if.ready = 1'b0;
    rst_ni       = 1'b0;
    calm_phase   = 1'b0;
    words_sent   = 0;
    quiet_cycles = 0;
    drained_mid  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners: isolated cells die on the first generation.
    send_word(OP_SET, 0, 0);
    send_word(OP_SET, GRID - 1, GRID - 1);
    send_word(OP_SET, 0, GRID - 1);
    send_word(OP_SET, GRID - 1, 0);
    send_word(OP_READ, GRID - 1, GRID - 1);
    send_word(OP_READ, 1, 1);
    send_word(OP_STEP, GRID - 1, 0);
    send_word(OP_READ, 0, 0);
    // L shapes in the lower and upper corners grow into blocks.
    send_word(OP_SET, 0, 0);
    send_word(OP_SET, 1, 0);
    send_word(OP_SET, 0, 1);
    send_word(OP_SET, GRID - 1, GRID - 2);
    send_word(OP_SET, GRID - 2, GRID - 1);
    send_word(OP_SET, GRID - 1, GRID - 1);
    send_word(OP_STEP, 0, GRID - 1);
    send_word(OP_READ, 1, 1);
    send_word(OP_READ, GRID - 2, GRID - 2);
    send_word(OP_CLEAR, 1, 1);
    send_word(OP_READ, 1, 1);
    send_word(OP_READ, GRID - 1, GRID - 1);
    send_word(OP_STEP, 0, 0);
    send_word(OP_READ, 0, 0);
    drain_results();

    // Random scenes, with one calm stretch and one more pause for the results.
    while (words_sent < WORD_TARGET) begin
      calm_phase = (words_sent >= 400) && (words_sent < 550);
      if ($urandom_range(9) < 7) begin
        pattern_scene();
      end else begin
        noise_scene();
      end
      if (!drained_mid && words_sent >= 650) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end
    calm_phase = 1'b0;
    drain_results();
    repeat (GRID + 8) @(posedge clk_i);

    $display("Run covered %0d words: %0d sets, %0d clears, %0d reads (%0d alive), %0d steps.",
             words_sent, board.op_count[OP_SET], board.op_count[OP_CLEAR],
             board.op_count[OP_READ], board.alive_reads, board.op_count[OP_STEP]);
    $display("Patterns were seeded at the corners, along the edges and in the interior.");
    if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
